@@ rtl/tbwl_pkg.sv @@
// shared types and constants of the bdp window limiter
// no dependencies; imported by tcp_bdp_window_limiter_core
package tbwl_pkg;

    localparam int BW_W   = 37;
    localparam int MSS_W  = 16;
    localparam int MODE_W = 2;
    localparam int SAMP_W = 24;
    localparam int WIN_W  = 32;
    localparam int IDX_W  = 1;

    // register reset values
    localparam logic [BW_W-1:0]  BW_RESET  = 37'd40000000;
    localparam logic [MSS_W-1:0] MSS_RESET = 16'd1500;

    // register indexes
    localparam logic [IDX_W-1:0] REG_BANDWIDTH = 1'b0;
    localparam logic [IDX_W-1:0] REG_SEGMENT   = 1'b1;

    // event kinds
    localparam logic [MODE_W-1:0] MODE_RTT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOSS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WIN  = 2'd2;

    // bdp = bw * srtt / 64e6, and 64e6 = 2^9 * 125000
    localparam int              SCALE_SH = 9;
    localparam int              DIVC_W   = 17;
    localparam logic [DIVC_W-1:0] DIV_C  = 17'd125000;

    localparam int IN_W  = 88;
    localparam int OUT_W = 96;

    typedef struct packed {
        logic [WIN_W-1:0]  reno_cwnd;
        logic [WIN_W-1:0]  bytes_in_flight;
        logic [SAMP_W-1:0] rtt_sample_us;
    } in_word_t;

    typedef struct packed {
        logic              rtt_rising;
        logic [SAMP_W-1:0] smoothed_rtt_us;
        logic [WIN_W-1:0]  cwnd;
        logic [WIN_W-1:0]  ssthresh;
    } result_t;

endpackage

@@ rtl/tcp_bdp_window_limiter_core.sv @@
// tcp congestion engine: ewma rtt, bdp-based ssthresh and window clamp
// depends on tbwl_pkg
//
// channel   dir  fields (low bit up)                                   handshake
// s_*       in   tuser: mode; tdata: rtt_sample_us, bytes_in_flight,   tvalid/tready
//                reno_cwnd
// m_*       out  tdata: ssthresh, cwnd, smoothed_rtt_us, rtt_rising,   tvalid/tready
//                zero pad
// cfg_*     in   cfg_index selects register, cfg_data value            cfg_we, no wait
//
// one word at a time; s_tready is high only while the engine is idle
// rtt sample: the rtt update state, then the finish state; unused mode: the finish state only
// window update: RTT_BITS+3 multiply steps (bit-serial, one srtt bit a cycle),
//   one range check, 32 divide steps by 125000 unless saturated, the finish state
// loss event: as window update plus 32 divide steps by a nonzero segment size
// a held output word does not block acceptance; the finish state waits for it
// rst_n clears state and control registers, sets config to reset values; no clearing pass
module tcp_bdp_window_limiter_core #(
    parameter int RTT_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // cfg
    input  logic                          cfg_we,
    input  logic [tbwl_pkg::IDX_W-1:0]    cfg_index,
    input  logic [tbwl_pkg::BW_W-1:0]     cfg_data,
    // input words
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: rtt_sample_us[23:0], bytes_in_flight[55:24], reno_cwnd[87:56]
    input  logic [tbwl_pkg::IN_W-1:0]     s_tdata,
    // s_tuser: mode[1:0]
    input  logic [tbwl_pkg::MODE_W-1:0]   s_tuser,
    // result words
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: ssthresh[31:0], cwnd[63:32], smoothed_rtt_us[87:64], rtt_rising[88], zeros
    output logic [tbwl_pkg::OUT_W-1:0]    m_tdata
);
    import tbwl_pkg::*;

    // widths that follow from the rtt width
    localparam int SR_W   = RTT_BITS + 3;            // srtt in 1/8 us
    localparam int PW     = BW_W + SR_W;             // product width
    localparam int LO_B   = SCALE_SH + WIN_W;        // first bit above quotient range
    localparam int HI_W   = PW - LO_B;
    localparam int HX_W   = (HI_W > DIVC_W) ? HI_W : DIVC_W;
    localparam int SX_W   = (RTT_BITS > SAMP_W) ? RTT_BITS : SAMP_W;
    localparam int STEPS  = (SR_W > WIN_W) ? SR_W : WIN_W;
    localparam int CNT_W  = $clog2(STEPS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RTT  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_CHK  = 3'd3;
    localparam logic [2:0] ST_DIVB = 3'd4;
    localparam logic [2:0] ST_DIVM = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    // control and config
    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SR_W-1:0]   srtt_reg, srtt_next;
    logic              rising_reg, rising_next;
    logic              seeded_reg, seeded_next;
    logic              oval_reg, oval_next;
    logic [BW_W-1:0]   bw_reg, bw_next;
    logic [MSS_W-1:0]  mss_reg, mss_next;

    // payload
    logic [MODE_W-1:0] mode_reg;
    in_word_t          in_reg;
    logic [PW-1:0]     acc_reg, acc_next;
    logic [SR_W-1:0]   mplr_reg, mplr_next;
    logic [DIVC_W-1:0] rem_reg, rem_next;
    logic [WIN_W-1:0]  work_reg, work_next;
    logic [WIN_W-1:0]  bdp_reg, bdp_next;
    result_t           out_reg, out_next;

    logic              accept;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = oval_reg;
    assign m_tdata  = {{(OUT_W - $bits(result_t)){1'b0}}, out_reg};

    // bit-serial multiply step, lsb of srtt first, sum lands in the top part
    logic [BW_W:0]     mul_sum;
    logic [PW-1:0]     acc_step;
    assign mul_sum  = {1'b0, acc_reg[PW-1:SR_W]} + (mplr_reg[0] ? {1'b0, bw_reg} : '0);
    assign acc_step = {mul_sum, acc_reg[SR_W-1:1]};

    // range check on the finished product
    logic [HX_W-1:0]   hi_x;
    logic              bdp_sat;
    assign hi_x    = HX_W'(acc_reg[PW-1:LO_B]);
    assign bdp_sat = hi_x >= HX_W'(DIV_C);

    // shared restoring divide step: 125000 for bdp, segment size for rounding
    logic [DIVC_W-1:0] dvs;
    logic [DIVC_W:0]   div_t;
    logic              div_ge;
    logic [DIVC_W-1:0] rem_step;
    logic [WIN_W-1:0]  work_step;
    assign dvs       = (state_reg == ST_DIVM) ? DIVC_W'(mss_reg) : DIV_C;
    assign div_t     = {rem_reg, work_reg[WIN_W-1]};
    assign div_ge    = div_t >= {1'b0, dvs};
    assign rem_step  = div_ge ? DIVC_W'(div_t - {1'b0, dvs}) : DIVC_W'(div_t);
    assign work_step = {work_reg[WIN_W-2:0], div_ge};

    // rtt update path
    logic [SX_W-1:0]     samp_x;
    logic [SX_W-1:0]     rmax_x;
    logic [RTT_BITS-1:0] samp_sat;
    logic [SR_W+2:0]     times7;
    logic [SR_W-1:0]     srtt_upd;
    assign samp_x   = SX_W'(in_reg.rtt_sample_us);
    assign rmax_x   = SX_W'({RTT_BITS{1'b1}});
    assign samp_sat = RTT_BITS'((samp_x > rmax_x) ? rmax_x : samp_x);
    assign times7   = {srtt_reg, 3'b000} - {3'b000, srtt_reg};
    assign srtt_upd = times7[SR_W+2:3] + SR_W'(samp_sat);

    // finish values
    logic [MSS_W:0]    two_mss;
    logic [WIN_W-1:0]  two_w;
    logic [WIN_W-1:0]  half_inf;
    logic [WIN_W-1:0]  reno_floor;
    logic [WIN_W-1:0]  loss_val;
    logic [WIN_W-1:0]  clamp_w;
    logic [WIN_W-1:0]  win_val;
    assign two_mss    = {mss_reg, 1'b0};
    assign two_w      = WIN_W'(two_mss);
    assign half_inf   = {1'b0, in_reg.bytes_in_flight[WIN_W-1:1]};
    assign reno_floor = (half_inf < two_w) ? two_w : half_inf;
    assign loss_val   = rising_reg ? bdp_reg
                      : ((bdp_reg > reno_floor) ? bdp_reg : reno_floor);
    assign clamp_w    = (in_reg.reno_cwnd < bdp_reg) ? in_reg.reno_cwnd : bdp_reg;
    assign win_val    = (clamp_w < WIN_W'(mss_reg)) ? WIN_W'(mss_reg) : clamp_w;

    // bdp ready, either saturated or from the divider
    logic              fin;
    logic [WIN_W-1:0]  fin_val;
    logic [WIN_W-1:0]  br_floor;
    assign br_floor = (fin_val < two_w) ? two_w : fin_val;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        srtt_next   = srtt_reg;
        rising_next = rising_reg;
        seeded_next = seeded_reg;
        oval_next   = oval_reg;
        bw_next     = bw_reg;
        mss_next    = mss_reg;
        acc_next    = acc_reg;
        mplr_next   = mplr_reg;
        rem_next    = rem_reg;
        work_next   = work_reg;
        bdp_next    = bdp_reg;
        out_next    = out_reg;
        fin         = 1'b0;
        fin_val     = work_step;

        if (oval_reg && m_tready)
        begin
            oval_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                REG_BANDWIDTH: bw_next  = cfg_data;
                REG_SEGMENT:   mss_next = cfg_data[MSS_W-1:0];
                default:       ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next  = '0;
                    acc_next  = '0;
                    mplr_next = srtt_reg;
                    case (s_tuser)
                        MODE_RTT:  state_next = ST_RTT;
                        MODE_LOSS: state_next = ST_MUL;
                        MODE_WIN:  state_next = ST_MUL;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_RTT:
            begin
                if (in_reg.rtt_sample_us != '0)
                begin
                    if (!seeded_reg)
                    begin
                        srtt_next   = {samp_sat, 3'b000};
                        seeded_next = 1'b1;
                        rising_next = 1'b0;
                    end
                    else
                    begin
                        srtt_next   = srtt_upd;
                        rising_next = srtt_upd > srtt_reg;
                    end
                end
                state_next = ST_DONE;
            end
            ST_MUL:
            begin
                acc_next  = acc_step;
                mplr_next = mplr_reg >> 1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SR_W - 1))
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (bdp_sat)
                begin
                    fin     = 1'b1;
                    fin_val = '1;
                end
                else
                begin
                    rem_next   = hi_x[DIVC_W-1:0];
                    work_next  = acc_reg[LO_B-1:SCALE_SH];
                    cnt_next   = '0;
                    state_next = ST_DIVB;
                end
            end
            ST_DIVB:
            begin
                rem_next  = rem_step;
                work_next = work_step;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WIN_W - 1))
                begin
                    fin     = 1'b1;
                    fin_val = work_step;
                end
            end
            ST_DIVM:
            begin
                rem_next  = rem_step;
                work_next = work_step;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WIN_W - 1))
                begin
                    // round down to whole segments: subtract the remainder
                    bdp_next   = bdp_reg - WIN_W'(rem_step);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!oval_reg || m_tready)
                begin
                    out_next.ssthresh        = (mode_reg == MODE_LOSS) ? loss_val : '0;
                    out_next.cwnd            = (mode_reg == MODE_WIN) ? win_val : '0;
                    out_next.smoothed_rtt_us = SAMP_W'(srtt_reg >> 3);
                    out_next.rtt_rising      = rising_reg;
                    oval_next                = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // bdp known: loss events with a nonzero segment size go on to segment rounding
        if (fin)
        begin
            if (mode_reg == MODE_LOSS)
            begin
                bdp_next = br_floor;
                if (mss_reg != '0)
                begin
                    work_next  = br_floor;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIVM;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            else
            begin
                bdp_next   = fin_val;
                state_next = ST_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            srtt_reg   <= '0;
            rising_reg <= 1'b0;
            seeded_reg <= 1'b0;
            oval_reg   <= 1'b0;
            bw_reg     <= BW_RESET;
            mss_reg    <= MSS_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            srtt_reg   <= srtt_next;
            rising_reg <= rising_next;
            seeded_reg <= seeded_next;
            oval_reg   <= oval_next;
            bw_reg     <= bw_next;
            mss_reg    <= mss_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= s_tuser;
            in_reg   <= in_word_t'(s_tdata);
        end
        acc_reg  <= acc_next;
        mplr_reg <= mplr_next;
        rem_reg  <= rem_next;
        work_reg <= work_next;
        bdp_reg  <= bdp_next;
        out_reg  <= out_next;
    end

    // a word in work blocks the next one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a word is in work");

    // rising flag only after the srtt has been seeded
    a_rise_seeded: assert property (@(posedge clk) disable iff (!rst_n)
        rising_reg |-> seeded_reg)
        else $error("rtt rising without a seeded srtt");

    // bdp divide keeps its remainder below the divisor
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVB) |-> (rem_reg < DIV_C))
        else $error("bdp divide remainder out of range");

    // a held result is not overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (oval_reg && !m_tready) |=> $stable(out_reg))
        else $error("pending result word overwritten");

endmodule
